>>> sv/mjt_pkg.sv
// shared types, constants and helpers of the motor to joint transmission
// no dependencies; imported by every module of the block but mjt_checker
package mjt_pkg;

    localparam int NUM_AXES  = 6;
    localparam int POS_W     = 32;
    localparam int ANG_W     = 36;
    localparam int Z_W       = 36;
    localparam int CORD_W    = 64;
    localparam int COEF_W    = 30;
    localparam int SQRT_BITS = 29;
    localparam int RAD_W     = 2 * SQRT_BITS;
    localparam int CFG_IDX_W = 3;
    localparam int LANE_LAT  = 3;

    localparam longint SL_Q12      = 64'sd319058944;
    localparam longint C_LIMIT     = 64'sd536870912;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint MI1_Q12     = 64'sd249456845;
    localparam longint NI1_Q12     = -64'sd120204001;
    localparam longint MI2_Q12     = -64'sd180633600;
    localparam longint NI2_Q12     = -64'sd209879040;

    typedef struct packed {
        logic signed [31:0] off;
        logic signed [31:0] gain;
    } axis_cfg_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] mi;
        logic signed [COEF_W-1:0] ni;
        logic        [RAD_W-1:0]  m;
    } link_coef_t;

    typedef struct packed {
        logic                     bad;
        logic signed [COEF_W-1:0] c;
    } link_side_t;

    localparam link_coef_t LINK1 = '{
        mi: COEF_W'(MI1_Q12),
        ni: COEF_W'(NI1_Q12),
        m:  RAD_W'(MI1_Q12 * MI1_Q12 + NI1_Q12 * NI1_Q12)
    };
    localparam link_coef_t LINK2 = '{
        mi: COEF_W'(MI2_Q12),
        ni: COEF_W'(NI2_Q12),
        m:  RAD_W'(MI2_Q12 * MI2_Q12 + NI2_Q12 * NI2_Q12)
    };

    // atan(2^-i) in q.30
    localparam logic [30:0] ATAN_TAB [32] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
        31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
        31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
    };

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

endpackage

>>> sv/mjt_lin_lane.sv
// one linear axis lane: offset difference, inverse gear multiply, round and saturate
// depends on mjt_pkg
module mjt_lin_lane #(
    parameter int SHIFT = 12
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] pos_a,
    input  logic signed [31:0] off_a,
    input  logic signed [31:0] pos_b,
    input  logic signed [31:0] off_b,
    input  logic               use_b,
    input  logic signed [31:0] gain,
    output logic signed [31:0] res
);
    import mjt_pkg::*;

    logic signed [32:0] da, db;
    logic signed [33:0] dd;
    logic signed [32:0] diff_next, diff_reg;
    logic signed [64:0] prod_reg;
    logic signed [65:0] rnd_sum, rnd_q;
    logic signed [31:0] res_reg;

    assign da = $signed({pos_a[31], pos_a}) - $signed({off_a[31], off_a});
    assign db = use_b ? ($signed({pos_b[31], pos_b}) - $signed({off_b[31], off_b})) : '0;
    assign dd = 34'(da) - 34'(db);

    // clamp the double difference to +-(2^32 - 1)
    always_comb begin
        if (dd > 34'sd4294967295) begin
            diff_next = 33'sd4294967295;
        end else if (dd < -34'sd4294967295) begin
            diff_next = -33'sd4294967295;
        end else begin
            diff_next = $signed(dd[32:0]);
        end
    end

    assign rnd_sum = 66'(prod_reg) + (66'sd1 <<< (SHIFT - 1));
    assign rnd_q   = rnd_sum >>> SHIFT;

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
            prod_reg <= diff_reg * gain;
            res_reg  <= sat32(68'(rnd_q));
        end
    end

    assign res = res_reg;

endmodule

>>> sv/mjt_isqrt.sv
// pipelined floor square root, one result bit per stage, with a sideband
// depends on mjt_pkg
module mjt_isqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [mjt_pkg::RAD_W-1:0]      rad,
    input  mjt_pkg::link_side_t            side_in,
    output logic [mjt_pkg::SQRT_BITS-1:0]  root,
    output mjt_pkg::link_side_t            side_out
);
    import mjt_pkg::*;

    logic [RAD_W-1:0]     rem_reg  [SQRT_BITS];
    logic [RAD_W-1:0]     rem_src  [SQRT_BITS];
    logic [RAD_W-1:0]     rem_nx   [SQRT_BITS];
    logic [SQRT_BITS-1:0] root_reg [SQRT_BITS];
    logic [SQRT_BITS-1:0] root_src [SQRT_BITS];
    logic [SQRT_BITS-1:0] root_nx  [SQRT_BITS];
    link_side_t           side_reg [SQRT_BITS];
    link_side_t           side_src [SQRT_BITS];
    logic [RAD_W-1:0]     test     [SQRT_BITS];

    always_comb begin
        rem_src[0]  = rad;
        root_src[0] = '0;
        side_src[0] = side_in;
        for (int k = 1; k < SQRT_BITS; k++) begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
        // stage k decides root bit SQRT_BITS-1-k
        for (int k = 0; k < SQRT_BITS; k++) begin
            test[k] = (RAD_W'(root_src[k]) << (SQRT_BITS - k))
                    | (RAD_W'(1) << (2 * (SQRT_BITS - 1 - k)));
            if (rem_src[k] >= test[k]) begin
                rem_nx[k]  = rem_src[k] - test[k];
                root_nx[k] = root_src[k] | (SQRT_BITS'(1) << (SQRT_BITS - 1 - k));
            end else begin
                rem_nx[k]  = rem_src[k];
                root_nx[k] = root_src[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_nx;
            root_reg <= root_nx;
            side_reg <= side_src;
        end
    end

    assign root     = root_reg[SQRT_BITS-1];
    assign side_out = side_reg[SQRT_BITS-1];

endmodule

>>> sv/mjt_cordic.sv
// pipelined vectoring cordic atan2 with quadrant pre-rotation and final rounding
// depends on mjt_pkg
module mjt_cordic #(
    parameter int ANGLE_FRAC_BITS = 28,
    parameter int CORDIC_STAGES   = 24
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [mjt_pkg::CORD_W-1:0] x_in,
    input  logic signed [mjt_pkg::CORD_W-1:0] y_in,
    input  logic                              bad_in,
    output logic signed [mjt_pkg::ANG_W-1:0]  ang,
    output logic                              bad_out
);
    import mjt_pkg::*;

    localparam int RND_SH = 30 - ANGLE_FRAC_BITS;

    logic signed [CORD_W-1:0] xs_reg [CORDIC_STAGES+1];
    logic signed [CORD_W-1:0] ys_reg [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]    zs_reg [CORDIC_STAGES+1];
    logic                     bs_reg [CORDIC_STAGES+1];
    logic signed [CORD_W-1:0] xs_nx  [CORDIC_STAGES+1];
    logic signed [CORD_W-1:0] ys_nx  [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]    zs_nx  [CORDIC_STAGES+1];
    logic                     bs_nx  [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]    at     [CORDIC_STAGES];
    logic signed [Z_W+1:0]    z2;
    logic signed [ANG_W-1:0]  ang_reg;
    logic                     bad_reg;

    always_comb begin
        // pre-rotation into the right half plane
        if (x_in < 0) begin
            if (y_in >= 0) begin
                xs_nx[0] = y_in;
                ys_nx[0] = -x_in;
                zs_nx[0] = Z_W'(HALF_PI_Q30);
            end else begin
                xs_nx[0] = -y_in;
                ys_nx[0] = x_in;
                zs_nx[0] = -Z_W'(HALF_PI_Q30);
            end
        end else begin
            xs_nx[0] = x_in;
            ys_nx[0] = y_in;
            zs_nx[0] = '0;
        end
        bs_nx[0] = bad_in;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            at[i] = Z_W'(ATAN_TAB[i]);
            if (ys_reg[i] >= 0) begin
                xs_nx[i+1] = xs_reg[i] + (ys_reg[i] >>> i);
                ys_nx[i+1] = ys_reg[i] - (xs_reg[i] >>> i);
                zs_nx[i+1] = zs_reg[i] + at[i];
            end else begin
                xs_nx[i+1] = xs_reg[i] - (ys_reg[i] >>> i);
                ys_nx[i+1] = ys_reg[i] + (xs_reg[i] >>> i);
                zs_nx[i+1] = zs_reg[i] - at[i];
            end
            bs_nx[i+1] = bs_reg[i];
        end
        // round half up to the angle format
        z2 = ((Z_W+2)'(zs_reg[CORDIC_STAGES]) <<< 1) + ((Z_W+2)'(1) <<< RND_SH);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xs_reg  <= xs_nx;
            ys_reg  <= ys_nx;
            zs_reg  <= zs_nx;
            bs_reg  <= bs_nx;
            ang_reg <= bs_reg[CORDIC_STAGES] ? '0 : ANG_W'(z2 >>> (RND_SH + 1));
            bad_reg <= bs_reg[CORDIC_STAGES];
        end
    end

    assign ang     = ang_reg;
    assign bad_out = bad_reg;

endmodule

>>> sv/mjt_linkage.sv
// linkage solve for one actuator: c, radicand, root, x/y combination, atan2
// depends on mjt_pkg, mjt_isqrt, mjt_cordic
module mjt_linkage #(
    parameter int ANGLE_FRAC_BITS = 28,
    parameter int CORDIC_STAGES   = 24
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [31:0]               l,
    input  mjt_pkg::link_coef_t              coef,
    output logic signed [mjt_pkg::ANG_W-1:0] ang,
    output logic                             bad
);
    import mjt_pkg::*;

    logic signed [63:0]       ll_reg;
    logic        [63:0]       llr;
    logic signed [44:0]       c_full;
    logic                     c_bad;
    logic signed [COEF_W-1:0] c2_reg, c3_reg;
    logic                     b2_reg, b3_reg;
    logic signed [59:0]       cc_reg;
    logic signed [RAD_W:0]    r_full;
    logic [RAD_W-1:0]         rad_reg;
    link_side_t               s4_reg, sq_side;
    logic [SQRT_BITS-1:0]     d;
    logic signed [COEF_W-1:0] d_s;
    logic signed [59:0]       p_mc_reg, p_nd_reg, p_nc_reg, p_md_reg;
    logic                     b5_reg, b6_reg;
    logic signed [61:0]       x_reg, y_reg;

    assign llr    = ($unsigned(ll_reg) + 64'd524288) >> 20;
    assign c_full = $signed({1'b0, llr[43:0]}) - 45'(SL_Q12);
    assign c_bad  = (c_full >= 45'(C_LIMIT)) || (c_full <= -45'(C_LIMIT));
    assign r_full = $signed({1'b0, coef.m}) - (RAD_W+1)'(cc_reg);
    assign d_s    = $signed({1'b0, d});

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg   <= l * l;
            c2_reg   <= c_full[COEF_W-1:0];
            b2_reg   <= c_bad;
            cc_reg   <= c2_reg * c2_reg;
            c3_reg   <= c2_reg;
            b3_reg   <= b2_reg;
            // out of reach: feed the root a zero and carry the flag
            rad_reg  <= (b3_reg || r_full < 0) ? '0 : r_full[RAD_W-1:0];
            s4_reg   <= '{bad: b3_reg || (r_full < 0), c: c3_reg};
            p_mc_reg <= coef.mi * sq_side.c;
            p_nd_reg <= coef.ni * d_s;
            p_nc_reg <= coef.ni * sq_side.c;
            p_md_reg <= coef.mi * d_s;
            b5_reg   <= sq_side.bad;
            x_reg    <= 62'(p_mc_reg) - 62'(p_nd_reg);
            y_reg    <= -(62'(p_nc_reg) + 62'(p_md_reg));
            b6_reg   <= b5_reg;
        end
    end

    mjt_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .rad      (rad_reg),
        .side_in  (s4_reg),
        .root     (d),
        .side_out (sq_side)
    );

    mjt_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_cordic (
        .aclk    (aclk),
        .en      (en),
        .x_in    (CORD_W'(x_reg)),
        .y_in    (CORD_W'(y_reg)),
        .bad_in  (b6_reg),
        .ang     (ang),
        .bad_out (bad)
    );

endmodule

>>> sv/motor_to_joint_transmission.sv
// motor to joint transmission of a six-axis arm: top level with lanes and merge
// depends on mjt_pkg, mjt_lin_lane, mjt_linkage
// throughput: one item per cycle unless the output stalls, fully pipelined; depth set by the 29-step
//   square root pipeline and the CORDIC_STAGES atan2 stages of the linkage lanes
// reset: aresetn low clears the pipeline valids, the output valid and all six
//   axis registers to zero
module motor_to_joint_transmission #(
    parameter int ANGLE_FRAC_BITS = 28,
    parameter int CORDIC_STAGES   = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // motor_pos_0 .. motor_pos_5, 32 bits each, from bit 0 up
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // joint_angle_0 .. joint_angle_5, 32 bits each, from bit 0 up
    output logic [1:0]   m_tuser,   // domain_error
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import mjt_pkg::*;

    localparam int LINK_LAT = 4 + SQRT_BITS + 2 + CORDIC_STAGES + 2;
    localparam int PIPE     = LANE_LAT + LINK_LAT + 1;
    localparam int LIN_SH   = 40 - ANGLE_FRAC_BITS;
    localparam int HP_SH    = 30 - ANGLE_FRAC_BITS;
    // pi/2 rounded half up to the angle format
    localparam logic signed [ANG_W-1:0] HP_F =
        ANG_W'((longint'(2) * HALF_PI_Q30 + (longint'(1) <<< HP_SH)) >>> (HP_SH + 1));

    typedef struct packed {
        logic signed [31:0] j5;
        logic signed [31:0] j4;
        logic signed [31:0] j3;
        logic signed [31:0] j0;
    } lin_set_t;

    axis_cfg_t          cfg_reg [NUM_AXES];
    logic [PIPE-1:0]    vld_reg;
    logic               out_load, adv;
    logic signed [31:0] mpos [NUM_AXES];
    logic signed [31:0] lin  [NUM_AXES];
    lin_set_t           dly_reg [LINK_LAT];
    logic signed [ANG_W-1:0] a1, a2;
    logic               bad1, bad2;
    lin_set_t           lin_d;
    logic signed [31:0] j1, j2, j3;
    logic [191:0]       mrg_data_reg;
    logic [1:0]         mrg_err_reg;
    logic [191:0]       out_data_reg;
    logic [1:0]         out_err_reg;
    logic               out_vld_reg, out_vld_next;

    // the pipe moves when the output register can load or its last stage is a bubble
    assign out_load  = !out_vld_reg || m_tready;
    assign adv       = out_load || !vld_reg[PIPE-1];
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            mpos[i] = $signed(s_tdata[i*POS_W +: POS_W]);
        end
    end

    // axis registers, writes past the last index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_AXES))) begin
            cfg_reg[cfg_index] <= axis_cfg_t'(cfg_data);
        end
    end

    // valid line alongside the data pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE-2:0], s_tvalid};
        end
    end

    // linear lanes, axis 4 takes away axis 3 travel
    mjt_lin_lane #(.SHIFT(LIN_SH)) u_lane0 (
        .aclk(aclk), .en(adv), .pos_a(mpos[0]), .off_a(cfg_reg[0].off),
        .pos_b('0), .off_b('0), .use_b(1'b0), .gain(cfg_reg[0].gain), .res(lin[0])
    );
    mjt_lin_lane #(.SHIFT(24)) u_lane1 (
        .aclk(aclk), .en(adv), .pos_a(mpos[1]), .off_a(cfg_reg[1].off),
        .pos_b('0), .off_b('0), .use_b(1'b0), .gain(cfg_reg[1].gain), .res(lin[1])
    );
    mjt_lin_lane #(.SHIFT(24)) u_lane2 (
        .aclk(aclk), .en(adv), .pos_a(mpos[2]), .off_a(cfg_reg[2].off),
        .pos_b('0), .off_b('0), .use_b(1'b0), .gain(cfg_reg[2].gain), .res(lin[2])
    );
    mjt_lin_lane #(.SHIFT(LIN_SH)) u_lane3 (
        .aclk(aclk), .en(adv), .pos_a(mpos[3]), .off_a(cfg_reg[3].off),
        .pos_b('0), .off_b('0), .use_b(1'b0), .gain(cfg_reg[3].gain), .res(lin[3])
    );
    mjt_lin_lane #(.SHIFT(LIN_SH)) u_lane4 (
        .aclk(aclk), .en(adv), .pos_a(mpos[4]), .off_a(cfg_reg[4].off),
        .pos_b(mpos[3]), .off_b(cfg_reg[3].off), .use_b(1'b1),
        .gain(cfg_reg[4].gain), .res(lin[4])
    );
    mjt_lin_lane #(.SHIFT(LIN_SH)) u_lane5 (
        .aclk(aclk), .en(adv), .pos_a(mpos[5]), .off_a(cfg_reg[5].off),
        .pos_b('0), .off_b('0), .use_b(1'b0), .gain(cfg_reg[5].gain), .res(lin[5])
    );

    // actuator lengths into the two linkage solvers
    mjt_linkage #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)
    ) u_link1 (
        .aclk(aclk), .en(adv), .l(lin[1]), .coef(LINK1), .ang(a1), .bad(bad1)
    );
    mjt_linkage #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)
    ) u_link2 (
        .aclk(aclk), .en(adv), .l(lin[2]), .coef(LINK2), .ang(a2), .bad(bad2)
    );

    // linear results wait for the linkage angles
    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_reg[0] <= '{j5: lin[5], j4: lin[4], j3: lin[3], j0: lin[0]};
            for (int k = 1; k < LINK_LAT; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    // merge: relative corrections of joints 2 and 3
    assign lin_d = dly_reg[LINK_LAT-1];
    assign j1    = sat32(68'(a1));
    assign j2    = sat32(68'(a2) - 68'(a1) - 68'(HP_F));
    assign j3    = sat32(68'(lin_d.j3) - 68'(a2));

    always_ff @(posedge aclk) begin
        if (adv) begin
            mrg_data_reg <= {lin_d.j5, lin_d.j4, j3, j2, j1, lin_d.j0};
            mrg_err_reg  <= {bad2, bad1};
        end
    end

    // output register, holds while the sink stalls
    assign out_vld_next = out_load ? vld_reg[PIPE-1] : out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && vld_reg[PIPE-1]) begin
            out_data_reg <= mrg_data_reg;
            out_err_reg  <= mrg_err_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule

>>> sv/mjt_checker.sv
// port-level checks of the motor to joint transmission, bound to the top level
// depends on motor_to_joint_transmission port names
module mjt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an unsolvable lower arm linkage gives a zero joint 1
    a_dom1: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[63:32] == 32'd0)
        else $error("joint 1 not zero on domain error");

    // an empty or draining output never blocks the input
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input blocked while output free");

    // reset empties the output
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind motor_to_joint_transmission mjt_checker u_mjt_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for motor_to_joint_transmission: directed and random motor samples
// depends on mjt_pkg and the motor_to_joint_transmission rtl
module testbench;
    import mjt_pkg::*;

    localparam int FRAC      = 28;
    localparam int STAGES    = 24;
    localparam int LATENCY   = STAGES + 42;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [191:0] angles;
        logic [1:0]   dom;
    } joint_set_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;   // motor_pos_0 .. motor_pos_5, 32 bits each, from bit 0 up
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;        // joint_angle_0 .. joint_angle_5, 32 bits each, from bit 0 up
    logic [1:0]   m_tuser;        // domain_error
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    // shadow copy of the six axis registers
    logic [63:0]  axis_reg [NUM_AXES];
    joint_set_t   pending_joints [$];
    int           fail_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_cycles = 0;
    int           quiet_cycles = 0;

    motor_to_joint_transmission #(
        .ANGLE_FRAC_BITS(FRAC),
        .CORDIC_STAGES(STAGES)
    ) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // floor division by 2^s on signed values
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_up(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_travel(longint d);
        if (d > 64'sd4294967295) return 64'sd4294967295;
        if (d < -64'sd4294967295) return -64'sd4294967295;
        return d;
    endfunction

    function automatic longint axis_offset(int a);
        return longint'($signed(axis_reg[a][63:32]));
    endfunction

    function automatic longint geared(longint diff, int a, int s);
        longint g;
        g = longint'($signed(axis_reg[a][31:0]));
        return clamp32(round_up(clamp_travel(diff) * g, s));
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, nx, ny;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI_Q30;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < STAGES && i < 32; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i); ny = y - shr_floor(x, i);
                z += longint'(ATAN_TAB[i]);
            end else begin
                nx = x - shr_floor(y, i); ny = y + shr_floor(x, i);
                z -= longint'(ATAN_TAB[i]);
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    // solves one linkage for actuator length len (q16.16); out_of_reach flags no solution
    function automatic longint link_angle(longint len, longint mi, longint ni,
                                          output bit out_of_reach);
        longint unsigned sq;
        longint c, mm, r, d;
        sq = longint'(len * len);
        c = longint'((sq + (64'd1 << 19)) >> 20) - SL_Q12;
        mm = mi * mi + ni * ni;
        out_of_reach = 1'b0;
        if (c >= C_LIMIT || c <= -C_LIMIT) begin
            out_of_reach = 1'b1;
            return 0;
        end
        r = mm - c * c;
        if (r < 0) begin
            out_of_reach = 1'b1;
            return 0;
        end
        d = int_root(r);
        return round_up(vector_angle(-(ni * c + mi * d), mi * c - ni * d), 30 - FRAC);
    endfunction

    function automatic joint_set_t predict_joints(logic [191:0] pos);
        joint_set_t js;
        longint m [6];
        longint j [6];
        longint trav3, l1, l2, a1, a2, hp;
        bit b1, b2;
        int sh;
        sh = 40 - FRAC;
        for (int i = 0; i < 6; i++) m[i] = longint'($signed(pos[32*i +: 32]));
        hp = round_up(HALF_PI_Q30, 30 - FRAC);
        j[0] = geared(m[0] - axis_offset(0), 0, sh);
        l1 = geared(m[1] - axis_offset(1), 1, 24);
        l2 = geared(m[2] - axis_offset(2), 2, 24);
        trav3 = m[3] - axis_offset(3);
        j[3] = geared(trav3, 3, sh);
        j[4] = geared(clamp_travel(m[4] - axis_offset(4)) - clamp_travel(trav3), 4, sh);
        j[5] = geared(m[5] - axis_offset(5), 5, sh);
        a1 = link_angle(l1, MI1_Q12, NI1_Q12, b1);
        a2 = link_angle(l2, MI2_Q12, NI2_Q12, b2);
        j[1] = clamp32(a1);
        j[2] = a2 - a1 - hp;
        j[3] = clamp32(j[3] - (j[2] + a1 + hp));
        j[2] = clamp32(j[2]);
        for (int i = 0; i < 6; i++) js.angles[32*i +: 32] = j[i][31:0];
        js.dom = {b2, b1};
        return js;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_axis(int idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx < NUM_AXES) axis_reg[idx] = val;
        @(negedge aclk);
    endtask

    // one motor sample; valid stays high across back-to-back transfers
    task automatic send_sample(logic [191:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_joints.push_back(predict_joints(pos));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_joints.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_joints.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                joint_set_t exp_js;
                exp_js = pending_joints.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (m_tdata[32*i +: 32] !== exp_js.angles[32*i +: 32]) begin
                        $error("joint_angle_%0d expected %0d got %0d", i,
                               $signed(exp_js.angles[32*i +: 32]),
                               $signed(m_tdata[32*i +: 32]));
                        fail_count++;
                    end
                end
                if (m_tuser !== exp_js.dom) begin
                    $error("domain_error expected %0d got %0d", exp_js.dom, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // receiver ready: random stalls, or a long forced hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [191:0] random_sample();
        logic [191:0] p;
        for (int i = 0; i < 6; i++) p[32*i +: 32] = $urandom;
        return p;
    endfunction

    // actuator positions that put the linkage near or inside its reachable range
    function automatic logic [31:0] near_reach_pos();
        // l about 279 (sqrt 77895) in q16.16, spread by up to 200 units either way
        return 32'(279 * 65536 + $signed($urandom_range(0, 400 * 65536)) - 200 * 65536);
    endfunction

    // unity gain and zero offset on the actuators keeps l equal to the motor position
    task automatic test_directed();
        logic [191:0] p;
        logic [31:0] edge_vals [6] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff,
                                       32'h00010000, 32'h01170000};
        for (int a = 0; a < 6; a++) write_axis(a, {32'h0, 32'h01000000});
        foreach (edge_vals[k]) begin
            p = '0;
            for (int i = 0; i < 6; i++) p[32*i +: 32] = edge_vals[(k + i) % 6];
            send_sample(p);
        end
        // linkage at the edge of reach and well inside
        for (int k = 0; k < 6; k++) begin
            p = random_sample();
            p[63:32] = near_reach_pos();
            p[95:64] = near_reach_pos();
            send_sample(p);
        end
        drain_results();
        // extreme offsets and gains drive the travel clamp and output saturation
        write_axis(0, {32'h80000000, 32'h7fffffff});
        write_axis(3, {32'h7fffffff, 32'h80000000});
        write_axis(4, {32'h80000000, 32'h7fffffff});
        write_axis(5, {32'hffffffff, 32'hffffffff});
        write_axis(1, {32'h7fffffff, 32'h80000000});
        write_axis(2, 64'h0);
        write_axis(7, 64'hdeadbeef_01234567);   // unmapped index, must be ignored
        p = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0, 32'h80000000, 32'h7fffffff};
        send_sample(p);
        send_sample(~p);
        send_sample('1);
        send_sample('0);
        drain_results();
    endtask

    task automatic random_phase(int count, int sidle, int ridle);
        logic [191:0] p;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int a = 0; a < 6; a++) begin
            if ($urandom_range(3) == 0)
                write_axis(a, {$urandom, $urandom});
            else
                write_axis(a, {32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)),
                               32'($urandom_range(1 << 23, 1 << 25))});
        end
        for (int n = 0; n < count; n++) begin
            p = random_sample();
            if ($urandom_range(99) < 75) begin
                p[63:32] = near_reach_pos();
                p[95:64] = near_reach_pos();
            end
            send_sample(p);
        end
        drain_results();
    endtask

    // receiver holds off while items keep coming, then the sender waits for the drain
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        for (int n = 0; n < 150; n++) send_sample(random_sample());
        drain_results();
    endtask

    initial begin
        for (int a = 0; a < NUM_AXES; a++) axis_reg[a] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        random_phase(380, 24, 86);
        random_phase(380, 86, 24);
        random_phase(380, 0, 0);
        test_backpressure();
        repeat (LATENCY + 10) @(negedge aclk);
        if (fail_count == 0 && pending_joints.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
